@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, bad, msg) \
  `ASSERT_AT(lbl, !(bad), msg)

`endif

@@ src/abg_pkg.sv @@
package abg_pkg;

  localparam int unsigned WORD_W        = 48;  // wide datapath word
  localparam int unsigned MUL_AW        = 32;
  localparam int unsigned MUL_BW        = 16;
  localparam int unsigned DEN_W         = 16;
  localparam int unsigned SQRT_IW       = 34;
  localparam int unsigned SQRT_OW       = SQRT_IW / 2;
  localparam int unsigned ENTRY_W       = 16;
  localparam int unsigned TBL_IW        = 2;   // index into a four-entry table
  localparam int unsigned COORD_W       = 24;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned STRIDE_W      = 9;
  localparam int unsigned CNT_W         = 3;
  localparam int unsigned CFG_W         = 64;

  localparam logic [COORD_W-1:0] COORD_POS_SAT = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] COORD_NEG_SAT = 24'h800000;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 9'd16;
  localparam logic [STRIDE_W-1:0] OFFSET_RST = 9'd128;
  localparam logic [CFG_W-1:0]    RATIO_RST  = 64'd4096;
  localparam logic [CFG_W-1:0]    SIZE_RST   = 64'd64;
  localparam logic [CNT_W-1:0]    COUNT_RST  = 3'd1;

  typedef enum logic [2:0] {
    CFG_STRIDE_X   = 3'd0,
    CFG_STRIDE_Y   = 3'd1,
    CFG_OFFSET     = 3'd2,
    CFG_RATIO_TBL  = 3'd3,
    CFG_SIZE_TBL   = 3'd4,
    CFG_RATIO_CNT  = 3'd5,
    CFG_SIZE_CNT   = 3'd6
  } cfg_idx_e;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_PA    = 13'b0000000000010,
    ST_PB    = 13'b0000000000100,
    ST_PC    = 13'b0000000001000,
    ST_AREA  = 13'b0000000010000,
    ST_RDIV  = 13'b0000000100000,
    ST_RSQRT = 13'b0000001000000,
    ST_RMUL  = 13'b0000010000000,
    ST_EW    = 13'b0000100000000,
    ST_EH    = 13'b0001000000000,
    ST_CSUM  = 13'b0010000000000,
    ST_CDIV  = 13'b0100000000000,
    ST_EMIT  = 13'b1000000000000
  } state_e;

  // Magnitude plus sign to saturated 24-bit two's complement.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [WORD_W-1:0] mag,
                                                   input logic neg);
    logic [COORD_W-1:0] res;
    if (!neg) begin
      res = (mag > WORD_W'(COORD_POS_SAT)) ? COORD_POS_SAT : mag[COORD_W-1:0];
    end else begin
      res = (mag > WORD_W'(COORD_NEG_SAT)) ? COORD_NEG_SAT
                                          : (~mag[COORD_W-1:0] + COORD_W'(1));
    end
    return res;
  endfunction

endpackage

@@ src/abg_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
module abg_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = $clog2(BW + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] acc_q, acc_d, a_q, a_d;
  logic [BW-1:0] b_q, b_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(BW);
      acc_d  = '0;
      a_d    = PW'(a_i);
      b_d    = b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ src/abg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module abg_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/abg_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module abg_sqrt #(
  parameter int unsigned IW = 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IW-1:0]       rad_i,
  output logic                done_o,
  output logic [IW/2-1:0]     root_o
);

  localparam int unsigned OW = IW / 2;
  localparam int unsigned CW = $clog2(OW + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] rad_q, rad_d;
  logic [OW:0]   rem_q, rem_d;
  logic [OW-1:0] root_q, root_d;
  logic [OW+2:0] cand, trial, diff;
  logic          ge;

  assign cand  = {rem_q, rad_q[IW-1:IW-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = cand >= trial;
  assign diff  = cand - trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(OW);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[OW:0] : cand[OW:0];
      root_d = {root_q[OW-2:0], ge};
      rad_d  = rad_q << 2;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ src/anchor_box_generator_unit.sv @@
// Anchor box generator.
// Input channel (in_valid_i/in_ready_o): one transfer carries a feature-map
// position (row_i, column_i). For it the block returns ratio_count*size_count
// boxes on the output channel (out_valid_o/out_ready_i), ratio-major, each with
// Q19.4 corners, anchor_index_o and last_anchor_o on the final box.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i; write
// only while no position is in flight.
// One position at a time: in_ready_o is high only when the block is idle.
// Everything runs bit-serially through one shift-add multiplier, one restoring
// divider and one square-root unit.
// Work per position: the two position centers and the area once, then per
// ratio a divide, root and multiply, then per box two extent multiplies and
// four corner divides.
// Reset: registers return to stride 16, offset 0.5, one ratio of 1.0, one size
// of 64; the block comes up idle with in_ready_o high.
// A stalled receiver holds the box in the output registers; work pauses
// until the transfer completes.
module anchor_box_generator_unit
  import abg_pkg::*;
#(
  parameter int GRID_DIM   = 1024,
  parameter int MAX_RATIOS = 4,
  parameter int MAX_SIZES  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [POS_W-1:0]           row_i,
  input  logic [POS_W-1:0]           column_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [COORD_W-1:0]  x_min_o,
  output logic signed [COORD_W-1:0]  y_min_o,
  output logic signed [COORD_W-1:0]  x_max_o,
  output logic signed [COORD_W-1:0]  y_max_o,
  output logic [3:0]                 anchor_index_o,
  output logic                       last_anchor_o,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  `include "assert_macros.svh"

  localparam logic [12:0]      GRID_LIM = 13'(GRID_DIM);
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(GRID_DIM - 1);
  localparam logic [CNT_W-1:0] NR_MAX   = CNT_W'(MAX_RATIOS);
  localparam logic [CNT_W-1:0] NS_MAX   = CNT_W'(MAX_SIZES);

  // Configuration registers
  logic [STRIDE_W-1:0] stride_x_q, stride_y_q, offset_q;
  logic [CFG_W-1:0]    ratio_tbl_q, size_tbl_q;
  logic [CNT_W-1:0]    ratio_cnt_q, size_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_x_q  <= STRIDE_RST;
      stride_y_q  <= STRIDE_RST;
      offset_q    <= OFFSET_RST;
      ratio_tbl_q <= RATIO_RST;
      size_tbl_q  <= SIZE_RST;
      ratio_cnt_q <= COUNT_RST;
      size_cnt_q  <= COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STRIDE_X:  stride_x_q  <= cfg_data_i[STRIDE_W-1:0];
        CFG_STRIDE_Y:  stride_y_q  <= cfg_data_i[STRIDE_W-1:0];
        CFG_OFFSET:    offset_q    <= cfg_data_i[STRIDE_W-1:0];
        CFG_RATIO_TBL: ratio_tbl_q <= cfg_data_i;
        CFG_SIZE_TBL:  size_tbl_q  <= cfg_data_i;
        CFG_RATIO_CNT: ratio_cnt_q <= cfg_data_i[CNT_W-1:0];
        CFG_SIZE_CNT:  size_cnt_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: zero stride/ratio/count read as one, counts clamp.
  logic [STRIDE_W-1:0] sx, sy, st;
  logic [CNT_W-1:0]    nr, ns;
  logic [5:0]          total;

  assign sx = (stride_x_q == '0) ? STRIDE_W'(1) : stride_x_q;
  assign sy = (stride_y_q == '0) ? STRIDE_W'(1) : stride_y_q;
  assign nr = (ratio_cnt_q == '0) ? CNT_W'(1)
            : ((ratio_cnt_q > NR_MAX) ? NR_MAX : ratio_cnt_q);
  assign ns = (size_cnt_q == '0) ? CNT_W'(1)
            : ((size_cnt_q > NS_MAX) ? NS_MAX : size_cnt_q);
  assign total = 6'(nr) * 6'(ns);

  // Sequencer state
  state_e              state_q, state_d;
  logic                launched_q, launched_d;
  logic                axis_q, axis_d;        // 0: x, 1: y
  logic [TBL_IW-1:0]   r_q, r_d, s_q, s_d;
  logic [1:0]          c_q, c_d;              // corner: bit0 y, bit1 max
  logic [3:0]          idx_q, idx_d;

  // Datapath registers
  logic [POS_W-1:0]    row_q, row_d, col_q, col_d;
  logic [WORD_W-1:0]   tmp_q, tmp_d, ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  logic [31:0]         area_q, area_d;
  logic [SQRT_IW-1:0]  rad_q, rad_d;
  logic [ENTRY_W-1:0]  base_w_q, base_w_d, base_h_q, base_h_d;
  logic [WORD_W-1:0]   hw_q, hw_d, hh_q, hh_d, m_q, m_d;
  logic signed [COORD_W-1:0] xmin_q, xmin_d, ymin_q, ymin_d;
  logic signed [COORD_W-1:0] xmax_q, xmax_d, ymax_q, ymax_d;

  // Shared units
  logic                mul_start, div_start, sqrt_start;
  logic                mul_done, div_done, sqrt_done, any_done;
  logic [MUL_AW-1:0]   mul_a;
  logic [MUL_BW-1:0]   mul_b;
  logic [WORD_W-1:0]   mul_p;
  logic [WORD_W-1:0]   div_num, div_quo;
  logic [DEN_W-1:0]    div_den;
  logic [SQRT_OW-1:0]  sqrt_root;

  logic [ENTRY_W-1:0]  ratio, size;
  logic [POS_W-1:0]    pos, row_c, col_c;
  logic [WORD_W-1:0]   st16, ctr_sel, h_sel, bh_sum;
  logic [SQRT_OW:0]    bw_sum;
  logic [COORD_W-1:0]  corner;
  logic                last;

  assign st  = axis_q ? sy : sx;
  assign pos = axis_q ? row_q : col_q;
  assign ratio = (ratio_tbl_q[ENTRY_W*r_q +: ENTRY_W] == '0) ? ENTRY_W'(1)
               : ratio_tbl_q[ENTRY_W*r_q +: ENTRY_W];
  assign size  = size_tbl_q[ENTRY_W*s_q +: ENTRY_W];
  assign row_c = ({3'b000, row_i} >= GRID_LIM) ? POS_MAX : row_i;
  assign col_c = ({3'b000, column_i} >= GRID_LIM) ? POS_MAX : column_i;

  // Per-corner selection: stride, center and half extent of the axis
  assign st16    = WORD_W'(c_q[0] ? sy : sx) << 4;
  assign ctr_sel = c_q[0] ? ctr_y_q : ctr_x_q;
  assign h_sel   = c_q[0] ? hh_q : hw_q;
  assign div_num = (state_q == ST_CDIV)
                 ? (m_q[WORD_W-1] ? (st16 - m_q) : (st16 + m_q))
                 : WORD_W'(area_q);
  assign div_den = (state_q == ST_CDIV) ? DEN_W'({(c_q[0] ? sy : sx), 5'b00000})
                                        : ratio;
  assign corner  = sat_coord(div_quo, m_q[WORD_W-1]);
  assign bw_sum  = {1'b0, sqrt_root} + (SQRT_OW + 1)'(1);
  assign bh_sum  = mul_p + WORD_W'(2048);
  assign last    = ({1'b0, r_q} == nr - CNT_W'(1)) && ({1'b0, s_q} == ns - CNT_W'(1));
  assign any_done = mul_done | div_done | sqrt_done;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_PA:   begin mul_a = MUL_AW'(pos);        mul_b = MUL_BW'(st); end
      ST_PB:   begin mul_a = MUL_AW'(offset_q);   mul_b = MUL_BW'(st - 1'b1); end
      ST_PC:   begin mul_a = tmp_q[MUL_AW-1:0];   mul_b = MUL_BW'(st); end
      ST_AREA: begin mul_a = MUL_AW'(sx);         mul_b = MUL_BW'(sy); end
      ST_RMUL: begin mul_a = MUL_AW'(base_w_q);   mul_b = ratio; end
      ST_EW:   begin mul_a = MUL_AW'(size);       mul_b = base_w_q; end
      ST_EH:   begin mul_a = MUL_AW'(size);       mul_b = base_h_q; end
      default: ;
    endcase
  end

  assign mul_start  = !launched_q && (state_q == ST_PA || state_q == ST_PB ||
                      state_q == ST_PC || state_q == ST_AREA || state_q == ST_RMUL ||
                      state_q == ST_EW || state_q == ST_EH);
  assign div_start  = !launched_q && (state_q == ST_RDIV || state_q == ST_CDIV);
  assign sqrt_start = !launched_q && (state_q == ST_RSQRT);

  abg_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p)
  );

  abg_div #(.NW(WORD_W), .DW(DEN_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  abg_sqrt #(.IW(SQRT_IW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(rad_q),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    axis_d     = axis_q;
    r_d        = r_q;
    s_d        = s_q;
    c_d        = c_q;
    idx_d      = idx_q;
    row_d      = row_q;
    col_d      = col_q;
    tmp_d      = tmp_q;
    ctr_x_d    = ctr_x_q;
    ctr_y_d    = ctr_y_q;
    area_d     = area_q;
    rad_d      = rad_q;
    base_w_d   = base_w_q;
    base_h_d   = base_h_q;
    hw_d       = hw_q;
    hh_d       = hh_q;
    m_d        = m_q;
    xmin_d     = xmin_q;
    ymin_d     = ymin_q;
    xmax_d     = xmax_q;
    ymax_d     = ymax_q;

    if (mul_start || div_start || sqrt_start) begin
      launched_d = 1'b1;
    end else if (any_done) begin
      launched_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          row_d   = row_c;
          col_d   = col_c;
          axis_d  = 1'b0;
          r_d     = '0;
          s_d     = '0;
          idx_d   = '0;
          state_d = ST_PA;
        end
      end
      ST_PA: begin
        if (mul_done) begin
          tmp_d   = mul_p;
          state_d = ST_PB;
        end
      end
      ST_PB: begin
        // pos*512*st + 2*off*(st-1)
        if (mul_done) begin
          tmp_d   = (tmp_q << 9) + (mul_p << 1);
          state_d = ST_PC;
        end
      end
      ST_PC: begin
        if (mul_done) begin
          if (axis_q) begin
            ctr_y_d = mul_p;
            state_d = ST_AREA;
          end else begin
            ctr_x_d = mul_p;
            axis_d  = 1'b1;
            state_d = ST_PA;
          end
        end
      end
      ST_AREA: begin
        // 4 * sx * sy * 4096
        if (mul_done) begin
          area_d  = {mul_p[17:0], 14'b0};
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (div_done) begin
          rad_d   = div_quo[SQRT_IW-1:0];
          state_d = ST_RSQRT;
        end
      end
      ST_RSQRT: begin
        if (sqrt_done) begin
          base_w_d = bw_sum[ENTRY_W:1];
          state_d  = ST_RMUL;
        end
      end
      ST_RMUL: begin
        if (mul_done) begin
          base_h_d = bh_sum[27:12];
          s_d      = '0;
          state_d  = ST_EW;
        end
      end
      ST_EW: begin
        // 256 * (extent numerator - stride), two's complement
        if (mul_done) begin
          hw_d    = (WORD_W'(mul_p[31:0]) - WORD_W'(sx)) << 8;
          state_d = ST_EH;
        end
      end
      ST_EH: begin
        if (mul_done) begin
          hh_d    = (WORD_W'(mul_p[31:0]) - WORD_W'(sy)) << 8;
          c_d     = '0;
          state_d = ST_CSUM;
        end
      end
      ST_CSUM: begin
        m_d     = c_q[1] ? (ctr_sel + h_sel) : (ctr_sel - h_sel);
        state_d = ST_CDIV;
      end
      ST_CDIV: begin
        if (div_done) begin
          case (c_q)
            2'd0:    xmin_d = corner;
            2'd1:    ymin_d = corner;
            2'd2:    xmax_d = corner;
            default: ymax_d = corner;
          endcase
          if (c_q == 2'd3) begin
            state_d = ST_EMIT;
          end else begin
            c_d     = c_q + 2'd1;
            state_d = ST_CSUM;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 4'd1;
          if (last) begin
            state_d = ST_IDLE;
          end else if ({1'b0, s_q} == ns - CNT_W'(1)) begin
            s_d     = '0;
            r_d     = r_q + 1'b1;
            state_d = ST_RDIV;
          end else begin
            s_d     = s_q + 1'b1;
            state_d = ST_EW;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      launched_q <= 1'b0;
      axis_q     <= 1'b0;
      r_q        <= '0;
      s_q        <= '0;
      c_q        <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      axis_q     <= axis_d;
      r_q        <= r_d;
      s_q        <= s_d;
      c_q        <= c_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    col_q    <= col_d;
    tmp_q    <= tmp_d;
    ctr_x_q  <= ctr_x_d;
    ctr_y_q  <= ctr_y_d;
    area_q   <= area_d;
    rad_q    <= rad_d;
    base_w_q <= base_w_d;
    base_h_q <= base_h_d;
    hw_q     <= hw_d;
    hh_q     <= hh_d;
    m_q      <= m_d;
    xmin_q   <= xmin_d;
    ymin_q   <= ymin_d;
    xmax_q   <= xmax_d;
    ymax_q   <= ymax_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_EMIT);
  assign x_min_o        = xmin_q;
  assign y_min_o        = ymin_q;
  assign x_max_o        = xmax_q;
  assign y_max_o        = ymax_q;
  assign anchor_index_o = idx_q;
  assign last_anchor_o  = last;

  `ASSERT_NEVER(a_in_out_exclusive, in_ready_o && out_valid_o,
                "input taken while a box is pending")
  `ASSERT_AT(a_single_unit_done, $onehot0({mul_done, div_done, sqrt_done}),
             "two arithmetic units finished together")
  `ASSERT_AT(a_index_in_range, out_valid_o |-> ({2'b00, idx_q} < total),
             "anchor index beyond ratio and size counts")
  `ASSERT_AT(a_last_to_idle, out_valid_o && out_ready_i && last_anchor_o |=> in_ready_o,
             "block not idle after final box")

endmodule

@@ test/anchor_box_checker.sv @@
`timescale 1ns / 1ps

module anchor_box_checker
  import abg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [POS_W-1:0]          row_i,
  input  logic [POS_W-1:0]          column_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [COORD_W-1:0]        x_min_i,
  input  logic [COORD_W-1:0]        y_min_i,
  input  logic [COORD_W-1:0]        x_max_i,
  input  logic [COORD_W-1:0]        y_max_i,
  input  logic [3:0]                anchor_index_i,
  input  logic                      last_anchor_i,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output int                        boxes_pending_o,
  output int                        fail_count_o
);

  typedef struct packed {
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
    logic [3:0]         anchor_index;
    logic               last_anchor;
  } box_t;

  box_t box_q[$];

  logic [STRIDE_W-1:0] stride_x_q, stride_y_q, offset_q;
  logic [CFG_W-1:0]    ratio_tbl_q, size_tbl_q;
  logic [CNT_W-1:0]    ratio_cnt_q, size_cnt_q;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Exact corner in Q19.4, rounded half away from zero, then saturated.
  function automatic logic [COORD_W-1:0] corner_q4(input longint pos, input longint st,
                                                   input longint off, input longint ext,
                                                   input bit upper);
    longint ctr, half, n, d, q;
    ctr  = pos * st * 512 * st + 2 * off * (st - 1) * st;
    half = 256 * (ext - st);
    n    = upper ? ctr + half : ctr - half;
    d    = 32 * st;
    q    = (n >= 0) ? (n + d / 2) / d : -((-n + d / 2) / d);
    if (q > 64'sd8388607)  q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[COORD_W-1:0];
  endfunction

  function automatic int unsigned clamp_cnt(input logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    return (c > 4) ? 4 : c;
  endfunction

  task automatic predict_boxes(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
    longint sx, sy, off;
    longint unsigned four_area, ratio, k, base_w, base_h, sz;
    int unsigned nr, ns, total, n;
    box_t b;
    sx  = (stride_x_q == 0) ? 1 : stride_x_q;
    sy  = (stride_y_q == 0) ? 1 : stride_y_q;
    off = offset_q;
    nr  = clamp_cnt(ratio_cnt_q);
    ns  = clamp_cnt(size_cnt_q);
    total = nr * ns;
    n = 0;
    // row/column are 10 bits, so the grid clamp never bites at GRID_DIM 1024
    four_area = 4 * sx * sy * 4096;
    for (int r = 0; r < nr; r++) begin
      ratio = (ratio_tbl_q >> (16 * r)) & 64'hFFFF;
      if (ratio == 0) ratio = 1;
      k      = int_sqrt(four_area / ratio);
      base_w = (k + 1) / 2;
      base_h = (base_w * ratio + 2048) >> 12;
      for (int s = 0; s < ns; s++) begin
        sz = (size_tbl_q >> (16 * s)) & 64'hFFFF;
        b.x_min        = corner_q4(col, sx, off, sz * base_w, 1'b0);
        b.y_min        = corner_q4(row, sy, off, sz * base_h, 1'b0);
        b.x_max        = corner_q4(col, sx, off, sz * base_w, 1'b1);
        b.y_max        = corner_q4(row, sy, off, sz * base_h, 1'b1);
        b.anchor_index = 4'(r * ns + s);
        b.last_anchor  = (n + 1 == total);
        box_q.push_back(b);
        n++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    box_t e;
    if (!rst_ni) begin
      stride_x_q   <= STRIDE_RST;
      stride_y_q   <= STRIDE_RST;
      offset_q     <= OFFSET_RST;
      ratio_tbl_q  <= RATIO_RST;
      size_tbl_q   <= SIZE_RST;
      ratio_cnt_q  <= COUNT_RST;
      size_cnt_q   <= COUNT_RST;
      box_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_STRIDE_X:  stride_x_q  <= cfg_data_i[STRIDE_W-1:0];
          CFG_STRIDE_Y:  stride_y_q  <= cfg_data_i[STRIDE_W-1:0];
          CFG_OFFSET:    offset_q    <= cfg_data_i[STRIDE_W-1:0];
          CFG_RATIO_TBL: ratio_tbl_q <= cfg_data_i;
          CFG_SIZE_TBL:  size_tbl_q  <= cfg_data_i;
          CFG_RATIO_CNT: ratio_cnt_q <= cfg_data_i[CNT_W-1:0];
          CFG_SIZE_CNT:  size_cnt_q  <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_boxes(row_i, column_i);
      if (out_valid_i && out_ready_i) begin
        if (box_q.size() == 0) begin
          $error("box transfer with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = box_q.pop_front();
          if (e.x_min !== x_min_i || e.y_min !== y_min_i || e.x_max !== x_max_i ||
              e.y_max !== y_max_i || e.anchor_index !== anchor_index_i ||
              e.last_anchor !== last_anchor_i)
            fail_count_o <= fail_count_o + 1;
          if (e.x_min !== x_min_i) $error("x_min exp %h got %h", e.x_min, x_min_i);
          if (e.y_min !== y_min_i) $error("y_min exp %h got %h", e.y_min, y_min_i);
          if (e.x_max !== x_max_i) $error("x_max exp %h got %h", e.x_max, x_max_i);
          if (e.y_max !== y_max_i) $error("y_max exp %h got %h", e.y_max, y_max_i);
          if (e.anchor_index !== anchor_index_i)
            $error("anchor_index exp %0d got %0d", e.anchor_index, anchor_index_i);
          if (e.last_anchor !== last_anchor_i)
            $error("last_anchor exp %0b got %0b", e.last_anchor, last_anchor_i);
        end
      end
    end
  end

  assign boxes_pending_o = box_q.size();

endmodule

@@ test/tb_anchor_box_generator_unit.sv @@
`timescale 1ns / 1ps

module tb_anchor_box_generator_unit;
  import abg_pkg::*;

  // Most random positions use small counts.
  localparam int CYCLE_LIMIT = 10_000_000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [POS_W-1:0]         row_i = '0;
  logic [POS_W-1:0]         column_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] x_min_o, y_min_o, x_max_o, y_max_o;
  logic [3:0]               anchor_index_o;
  logic                     last_anchor_o;
  logic                     cfg_we_i = 1'b0;
  logic [2:0]               cfg_idx_i = '0;
  logic [CFG_W-1:0]         cfg_data_i = '0;

  int boxes_pending;
  int fail_count;
  int send_idle_pct = 0;   // chance in percent that the sender skips a cycle
  int recv_idle_pct = 0;   // chance in percent that the receiver stalls
  int cycle_cnt = 0;

  always #1 clk_i = ~clk_i;

  anchor_box_generator_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .row_i, .column_i,
    .out_valid_o, .out_ready_i, .x_min_o, .y_min_o, .x_max_o, .y_max_o,
    .anchor_index_o, .last_anchor_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  anchor_box_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .row_i, .column_i,
    .out_valid_i(out_valid_o), .out_ready_i, .x_min_i(x_min_o), .y_min_i(y_min_o),
    .x_max_i(x_max_o), .y_max_i(y_max_o), .anchor_index_i(anchor_index_o),
    .last_anchor_i(last_anchor_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .boxes_pending_o(boxes_pending), .fail_count_o(fail_count)
  );

  // Receiver back-pressure, re-rolled every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One position transfer; valid holds until the block takes it.
  // in_ready_o is checked at the falling edge, where it is stable.
  task automatic send_pos(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    row_i      = r;
    column_i   = c;
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Every position yields at least one box, so an empty queue plus a
  // short pause means the block is idle again.
  task automatic drain();
    while (boxes_pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic load_cfg(input logic [8:0] sx, input logic [8:0] sy, input logic [8:0] off,
                          input logic [63:0] rt, input logic [63:0] st,
                          input logic [2:0] rc, input logic [2:0] sc);
    drain();
    write_reg(CFG_STRIDE_X, 64'(sx));
    write_reg(CFG_STRIDE_Y, 64'(sy));
    write_reg(CFG_OFFSET, 64'(off));
    write_reg(CFG_RATIO_TBL, rt);
    write_reg(CFG_SIZE_TBL, st);
    write_reg(CFG_RATIO_CNT, 64'(rc));
    write_reg(CFG_SIZE_CNT, 64'(sc));
  endtask

  task automatic random_cfg();
    logic [8:0] sx, sy;
    logic [2:0] rc, sc;
    if ($urandom_range(3) == 0) begin
      sx = 9'($urandom_range(511));
      sy = 9'($urandom_range(511));
    end else begin
      sx = 9'($urandom_range(1, 64));
      sy = 9'($urandom_range(1, 64));
    end
    // keep most positions at one to four boxes; the full 4x4 now and then
    if ($urandom_range(7) == 0) begin
      rc = 3'($urandom_range(7));
      sc = 3'($urandom_range(7));
    end else begin
      rc = 3'($urandom_range(1, 2));
      sc = 3'($urandom_range(1, 2));
    end
    load_cfg(sx, sy, 9'($urandom_range(511)), {$urandom, $urandom}, {$urandom, $urandom},
             rc, sc);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset settings at grid corners.
    send_pos(10'd0, 10'd0);
    send_pos(10'd1023, 10'd1023);
    send_pos(10'd0, 10'd1023);
    // Zero strides, zero offset, zero ratio entry, zero size, counts clamped up from 0.
    load_cfg(9'd0, 9'd0, 9'd0, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
             3'd0, 3'd0);
    send_pos(10'd5, 10'd7);
    // Largest strides and offset, extreme ratios/sizes, counts clamped down: saturation.
    load_cfg(9'd511, 9'd511, 9'd511, 64'hFFFF_0001_0000_FFFF, 64'hFFFF_0000_0001_FFFF,
             3'd7, 3'd7);
    send_pos(10'd1023, 10'd1023);
    send_pos(10'd0, 10'd0);
    send_pos(10'd1023, 10'd0);
    // X stride 256, y stride 1, full offset, unit ratio and a mixed table.
    load_cfg(9'd256, 9'd1, 9'd256, 64'h2000_1000_0800_1000, 64'h0200_0080_0020_0008,
             3'd4, 3'd4);
    send_pos(10'd512, 10'd1);
    send_pos(10'h2AA, 10'h155);
    // X stride 1, y stride 511, big sizes: negative corners at 0, saturated y_max at 1023.
    load_cfg(9'd1, 9'd511, 9'd0, 64'h0001_0001_FFFF_FFFF, 64'h0000_0000_FFFF_8000,
             3'd2, 3'd2);
    send_pos(10'd0, 10'd0);
    send_pos(10'd1023, 10'd1023);

    // Random: three back-pressure profiles, config reshuffled between groups.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 26 : 0;
      for (int g = 0; g < 6; g++) begin
        random_cfg();
        for (int i = 0; i < 15; i++) begin
          send_pos(10'($urandom_range(1023)), 10'($urandom_range(1023)));
          if ($urandom_range(15) == 0) drain();  // sender waits for all boxes
        end
      end
    end

    while (boxes_pending != 0) @(negedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
